// File: src/pma_pkg.sv
package pma_pkg;

	localparam int unsigned DATA_W = 30;
	localparam int unsigned EXP_W = 31;

	localparam logic [DATA_W-1:0] MODULUS = 30'd998244353;
	localparam logic [EXP_W-1:0] INV_EXP = 31'd998244351;

	// barrett factor floor(2^60 / modulus)
	localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'(MODULUS);
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_POW = 3'd3,
		KIND_INV = 3'd4
	} kind_t;

	typedef enum logic {
		DST_ACC,
		DST_BASE
	} dst_t;

	typedef enum logic [1:0] {
		SEL_AB,
		SEL_ACC_BASE,
		SEL_BASE_BASE
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHECK,
		ST_ISSUE_ACC,
		ST_ISSUE_SQ,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     load;
		logic     issue;
		mul_sel_t sel;
		dst_t     dst;
		logic     exp_shift;
		logic     finish;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  exp_zero;
		logic  exp_bit;
		logic  exp_last;
		logic  mul_busy;
	} ctrl_stat_t;

endpackage

// File: src/pma_mulmod.sv
module pma_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  pma_pkg::dst_t                 in_dst,
	input  logic [pma_pkg::DATA_W-1:0]    x,
	input  logic [pma_pkg::DATA_W-1:0]    y,
	output logic                          out_valid,
	output pma_pkg::dst_t                 out_dst,
	output logic [pma_pkg::DATA_W-1:0]    out_value,
	output logic                          busy
);
	import pma_pkg::*;

	localparam logic [31:0] M1 = 32'(MODULUS);
	localparam logic [31:0] M2 = 32'({MODULUS, 1'b0});

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	dst_t        dst_s1, dst_s2, dst_s3, dst_s4;
	logic [59:0] prod_s1;
	logic [61:0] quot_s2;
	logic [31:0] prod_lo_s2, prod_lo_s3;
	logic [31:0] qm_s3;
	logic [DATA_W-1:0] value_s4;

	logic [31:0] qm_lo;
	logic [31:0] diff;
	logic [31:0] diff_red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// full product, quotient estimate, quotient times modulus, correction
	always_comb begin
		qm_lo = 32'(quot_s2[61:31]) * M1;
		diff = prod_lo_s3 - qm_s3;
		if (diff >= M2) begin
			diff_red = diff - M2;
		end else if (diff >= M1) begin
			diff_red = diff - M1;
		end else begin
			diff_red = diff;
		end
	end

	always_ff @(posedge clk) begin
		dst_s1     <= in_dst;
		prod_s1    <= 60'(x) * 60'(y);
		dst_s2     <= dst_s1;
		quot_s2    <= 62'(prod_s1[59:29]) * 62'(BARRETT_MU);
		prod_lo_s2 <= prod_s1[31:0];
		dst_s3     <= dst_s2;
		qm_s3      <= qm_lo;
		prod_lo_s3 <= prod_lo_s2;
		dst_s4     <= dst_s3;
		value_s4   <= diff_red[DATA_W-1:0];
	end

	assign out_valid = valid_s4;
	assign out_dst   = dst_s4;
	assign out_value = value_s4;
	assign busy      = valid_s1 | valid_s2 | valid_s3 | valid_s4;

endmodule

// File: src/pma_datapath.sv
module pma_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    kind,
	input  logic [pma_pkg::DATA_W-1:0]    operand_a,
	input  logic [pma_pkg::DATA_W-1:0]    operand_b,
	input  logic [pma_pkg::EXP_W-1:0]     exponent,
	input  pma_pkg::ctrl_cmd_t            cmd,
	output pma_pkg::ctrl_stat_t           stat,
	output logic [pma_pkg::DATA_W-1:0]    result
);
	import pma_pkg::*;

	function automatic logic [DATA_W-1:0] reduce_once(input logic [DATA_W-1:0] v);
		return (v >= MODULUS) ? v - MODULUS : v;
	endfunction

	kind_t             kind_q;
	logic [DATA_W-1:0] a_q, b_q, acc_q, base_q, result_q;
	logic [EXP_W-1:0]  exp_q;

	logic [DATA_W-1:0] mul_x, mul_y;
	logic              mul_valid;
	dst_t              mul_dst;
	logic [DATA_W-1:0] mul_value;
	logic              mul_busy;

	logic [DATA_W-1:0] addend;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] sum_red;
	kind_t             kind_in;
	logic [EXP_W-1:0]  exp_init;

	always_comb begin
		kind_in = kind_t'(kind);
		case (kind_in)
			KIND_POW: exp_init = exponent;
			KIND_INV: exp_init = INV_EXP;
			default:  exp_init = '0;
		endcase
	end

	always_comb begin
		addend = (kind_q == KIND_SUB) ? MODULUS - b_q : b_q;
		sum = {1'b0, a_q} + {1'b0, addend};
		sum_red = (sum >= {1'b0, MODULUS}) ? DATA_W'(sum - {1'b0, MODULUS}) : sum[DATA_W-1:0];
	end

	always_comb begin
		case (cmd.sel)
			SEL_AB: begin
				mul_x = a_q;
				mul_y = b_q;
			end
			SEL_ACC_BASE: begin
				mul_x = acc_q;
				mul_y = base_q;
			end
			SEL_BASE_BASE: begin
				mul_x = base_q;
				mul_y = base_q;
			end
			default: begin
				mul_x = a_q;
				mul_y = b_q;
			end
		endcase
	end

	pma_mulmod u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.issue),
		.in_dst    (cmd.dst),
		.x         (mul_x),
		.y         (mul_y),
		.out_valid (mul_valid),
		.out_dst   (mul_dst),
		.out_value (mul_value),
		.busy      (mul_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_in;
			a_q    <= reduce_once(operand_a);
			b_q    <= reduce_once(operand_b);
			base_q <= reduce_once(operand_a);
			acc_q  <= DATA_W'(1);
			exp_q  <= exp_init;
		end else begin
			if (mul_valid) begin
				if (mul_dst == DST_ACC) begin
					acc_q <= mul_value;
				end else begin
					base_q <= mul_value;
				end
			end
			if (cmd.exp_shift) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.finish) begin
			case (kind_q)
				KIND_ADD, KIND_SUB:           result_q <= sum_red;
				KIND_MUL, KIND_POW, KIND_INV: result_q <= acc_q;
				default:                      result_q <= '0;
			endcase
		end
	end

	assign stat.kind     = kind_q;
	assign stat.exp_zero = (exp_q == '0);
	assign stat.exp_bit  = exp_q[0];
	assign stat.exp_last = (exp_q[EXP_W-1:1] == '0);
	assign stat.mul_busy = mul_busy;
	assign result        = result_q;

endmodule

// File: src/pma_ctrl.sv
module pma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pma_pkg::ctrl_stat_t  stat,
	output pma_pkg::ctrl_cmd_t   cmd,
	output logic                 busy,
	output logic                 done
);
	import pma_pkg::*;

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.kind)
					KIND_MUL: begin
						cmd.issue = 1'b1;
						cmd.sel = SEL_AB;
						cmd.dst = DST_ACC;
						state_d = ST_WAIT;
					end
					KIND_POW, KIND_INV: state_d = ST_CHECK;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_CHECK: begin
				state_d = stat.exp_zero ? ST_FINISH : ST_ISSUE_ACC;
			end
			ST_ISSUE_ACC: begin
				cmd.issue = stat.exp_bit;
				cmd.sel = SEL_ACC_BASE;
				cmd.dst = DST_ACC;
				// no square needed after the top exponent bit
				state_d = stat.exp_last ? ST_WAIT : ST_ISSUE_SQ;
			end
			ST_ISSUE_SQ: begin
				cmd.issue = 1'b1;
				cmd.sel = SEL_BASE_BASE;
				cmd.dst = DST_BASE;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.exp_shift = 1'b1;
					state_d = stat.exp_last ? ST_FINISH : ST_ISSUE_ACC;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: src/prime_modular_arithmetic_unit_core.sv
// add, subtract and unused kinds go straight to finish; power finishes on a zero exponent;
// otherwise power and inverse (exponent modulus - 2) walk the exponent bits from the lowest;
// per bit, acc *= base if set, base *= base unless it is the top bit, in the 4-stage multiplier
// a new request is taken in the cycle that done is shown; one request in flight at a time
// the receiver cannot stall; asynchronous reset clears the controller and multiplier valids
module prime_modular_arithmetic_unit_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    kind,
	input  logic [pma_pkg::DATA_W-1:0]    operand_a,
	input  logic [pma_pkg::DATA_W-1:0]    operand_b,
	input  logic [pma_pkg::EXP_W-1:0]     exponent,
	output logic                          busy,
	output logic                          done,
	output logic [pma_pkg::DATA_W-1:0]    result
);
	import pma_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	pma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pma_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.exponent  (exponent),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result < MODULUS))
		else $error("result not reduced");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

endmodule

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pma_pkg::*;

	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;
	localparam logic [DATA_W-1:0] TOP_OPERAND = {DATA_W{1'b1}};
	localparam logic [EXP_W-1:0] TOP_EXPONENT = {EXP_W{1'b1}};
	localparam int unsigned RANDOM_REQUESTS = 900;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 20;

	typedef struct {
		logic [2:0]        kind;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		logic [EXP_W-1:0]  exponent;
		logic              drain;
	} request_t;

	typedef struct {
		request_t          req;
		logic [DATA_W-1:0] value;
	} expected_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] kind = '0;
	logic [DATA_W-1:0] operand_a = '0;
	logic [DATA_W-1:0] operand_b = '0;
	logic [EXP_W-1:0] exponent = '0;
	logic busy;
	logic done;
	logic [DATA_W-1:0] result;

	request_t pending_requests[$];
	expected_t expected_results[$];
	request_t current_request;
	int unsigned issued_count = 0;
	int unsigned received_count = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	prime_modular_arithmetic_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.exponent  (exponent),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] reduce_operand(input logic [DATA_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w >= 64'(MODULUS)) ? w - 64'(MODULUS) : w;
	endfunction

	function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y);
		return (x * y) % 64'(MODULUS);
	endfunction

	function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [EXP_W-1:0] e);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = base;
		for (int i = 0; i < EXP_W; i++) begin
			if (e[i])
				acc = mod_product(acc, sq);
			sq = mod_product(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [DATA_W-1:0] predict_result(input request_t req);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		a = reduce_operand(req.operand_a);
		b = reduce_operand(req.operand_b);
		case (req.kind)
			KIND_ADD: begin
				r = a + b;
				if (r >= 64'(MODULUS))
					r = r - 64'(MODULUS);
			end
			KIND_SUB: begin
				r = a + (64'(MODULUS) - b);
				if (r >= 64'(MODULUS))
					r = r - 64'(MODULUS);
			end
			KIND_MUL: r = mod_product(a, b);
			KIND_POW: r = mod_power(a, req.exponent);
			KIND_INV: r = mod_power(a, INV_EXP);
			default: r = 64'd0;
		endcase
		return r[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] random_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return MODULUS - 1'b1;
			2: return MODULUS + DATA_W'($urandom_range(0, 3));
			3: return TOP_OPERAND - DATA_W'($urandom_range(0, 3));
			4: return DATA_W'($urandom);
			default: return DATA_W'($urandom_range(0, MODULUS - 1));
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] random_exponent();
		int unsigned w;
		logic [31:0] mask;
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, EXP_W) : $urandom_range(0, 8);
		if (w == 0)
			return '0;
		mask = (32'd1 << w) - 32'd1;
		return EXP_W'(($urandom & mask) | (32'd1 << (w - 1)));
	endfunction

	function automatic request_t make_request(input logic [2:0] k, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [EXP_W-1:0] e);
		request_t req;
		req.kind = k;
		req.operand_a = a;
		req.operand_b = b;
		req.exponent = e;
		req.drain = 1'b0;
		return req;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back('{req: current_request,
					value: predict_result(current_request)});
				issued_count++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending_requests.size() == 0) begin
					start <= 1'b0;
				end else if (pending_requests[0].drain && issued_count != received_count) begin
					start <= 1'b0;
				end else begin
					current_request = pending_requests.pop_front();
					start <= 1'b1;
					kind <= current_request.kind;
					operand_a <= current_request.operand_a;
					operand_b <= current_request.operand_b;
					exponent <= current_request.exponent;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
					end
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		expected_t exp_item;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", result));
			end else begin
				exp_item = expected_results.pop_front();
				received_count <= received_count + 1;
				if (result !== exp_item.value)
					report_mismatch($sformatf("kind %0d a %0d b %0d e %0d: result %0d, want %0d",
						exp_item.req.kind, exp_item.req.operand_a, exp_item.req.operand_b,
						exp_item.req.exponent, result, exp_item.value));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		request_t req;
		logic [2:0] k;

		// edge values of each operation
		pending_requests.push_back(make_request(KIND_ADD, '0, '0, '0));
		pending_requests.push_back(make_request(KIND_ADD, MODULUS - 1'b1, MODULUS - 1'b1,
			TOP_EXPONENT));
		pending_requests.push_back(make_request(KIND_ADD, MODULUS - 1'b1, 30'd1, '0));
		pending_requests.push_back(make_request(KIND_SUB, '0, MODULUS - 1'b1, '0));
		pending_requests.push_back(make_request(KIND_SUB, 30'd5, 30'd3, TOP_EXPONENT));
		pending_requests.push_back(make_request(KIND_SUB, '0, '0, '0));
		pending_requests.push_back(make_request(KIND_MUL, MODULUS - 1'b1, MODULUS - 1'b1,
			TOP_EXPONENT));
		pending_requests.push_back(make_request(KIND_MUL, '0, TOP_OPERAND, '0));
		// zero exponent and zero base, together and each alone
		req = make_request(KIND_POW, '0, TOP_OPERAND, '0);
		req.drain = 1'b1;
		pending_requests.push_back(req);
		pending_requests.push_back(make_request(KIND_POW, 30'd5, '0, '0));
		pending_requests.push_back(make_request(KIND_POW, '0, '0, 31'd5));
		pending_requests.push_back(make_request(KIND_POW, 30'd2, MODULUS - 1'b1, TOP_EXPONENT));
		pending_requests.push_back(make_request(KIND_POW, MODULUS - 1'b1, '0,
			31'd1 << (EXP_W - 1)));
		pending_requests.push_back(make_request(KIND_INV, '0, '0, '0));
		pending_requests.push_back(make_request(KIND_INV, 30'd1, TOP_OPERAND, TOP_EXPONENT));
		pending_requests.push_back(make_request(KIND_INV, MODULUS - 1'b1, '0, '0));
		pending_requests.push_back(make_request(KIND_INV, 30'd2, '0, 31'd3));
		// operands at or above the modulus
		pending_requests.push_back(make_request(KIND_ADD, TOP_OPERAND, MODULUS, '0));
		pending_requests.push_back(make_request(KIND_SUB, MODULUS, TOP_OPERAND, '0));
		pending_requests.push_back(make_request(KIND_MUL, MODULUS, TOP_OPERAND, '0));
		pending_requests.push_back(make_request(KIND_INV, TOP_OPERAND, '0, '0));
		pending_requests.push_back(make_request(KIND_POW, MODULUS + 1'b1, '0, 31'd3));
		// unused kinds
		for (int i = KIND_UNUSED_FIRST; i <= KIND_UNUSED_LAST; i++)
			pending_requests.push_back(make_request(3'(i), random_operand(), random_operand(),
				random_exponent()));

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(KIND_UNUSED_FIRST,
				KIND_UNUSED_LAST)) : 3'($urandom_range(KIND_ADD, KIND_INV));
			req = make_request(k, random_operand(), random_operand(),
				($urandom_range(0, 1) == 0) ? random_exponent() : EXP_W'($urandom));
			if (k == KIND_POW)
				req.exponent = random_exponent();
			req.drain = ($urandom_range(0, 99) == 0);
			pending_requests.push_back(req);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
src/pma_pkg.sv
src/pma_mulmod.sv
src/pma_datapath.sv
src/pma_ctrl.sv
src/prime_modular_arithmetic_unit_core.sv
test/tb.sv
